// ===== hdl/foc_current_loop_assert.svh =====
// Assertion macros for the field-oriented current loop.
// Used by the controller and top-level modules; no other dependencies.
`ifndef FOC_CURRENT_LOOP_ASSERT_SVH
`define FOC_CURRENT_LOOP_ASSERT_SVH
`ifndef SYNTH
`define FOC_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define FOC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`else
`define FOC_ASSERT_IMPL(label, clk, rst_n, prop)
`define FOC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`endif
`endif

// ===== hdl/foc_pkg.sv =====
// Shared types, constants and the sine table function for the current loop.
// No dependencies.
package foc_pkg;
    localparam int SineTableBitsDefault = 10;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 16;

    localparam logic [CfgIdxWidth-1:0] REG_KP_D    = 3'd0;
    localparam logic [CfgIdxWidth-1:0] REG_KI_D    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] REG_KP_Q    = 3'd2;
    localparam logic [CfgIdxWidth-1:0] REG_KI_Q    = 3'd3;
    localparam logic [CfgIdxWidth-1:0] REG_LIMIT_D = 3'd4;
    localparam logic [CfgIdxWidth-1:0] REG_LIMIT_Q = 3'd5;

    // Datapath step selects.
    localparam logic [3:0] OP_LOAD    = 4'd0;
    localparam logic [3:0] OP_BETA    = 4'd1;
    localparam logic [3:0] OP_PARK_D  = 4'd2;
    localparam logic [3:0] OP_PARK_Q  = 4'd3;
    localparam logic [3:0] OP_PI_D    = 4'd4;
    localparam logic [3:0] OP_PI_Q    = 4'd5;
    localparam logic [3:0] OP_IPARK_A = 4'd6;
    localparam logic [3:0] OP_IPARK_B = 4'd7;
    localparam logic [3:0] OP_IDLE    = 4'd8;

    typedef struct packed {
        logic       valid;
        logic [3:0] op;
        logic       phase;
    } t_dp_cmd;

    typedef struct packed {
        logic [15:0] kp_d;
        logic [15:0] ki_d;
        logic [15:0] kp_q;
        logic [15:0] ki_q;
        logic [14:0] limit_d;
        logic [14:0] limit_q;
    } t_cfg;

    // Quarter-wave polynomial sine, Q1.14 result.
    function automatic logic signed [16:0] sine_entry(input logic [15:0] p);
        logic [1:0]  quad;
        logic [15:0] x;
        logic [31:0] x2;
        logic [31:0] t;
        logic [47:0] s;
        quad = p[15:14];
        x = {1'b0, p[13:0], 1'b0};
        if (quad[0]) x = 16'd32768 - x;
        x2 = ({16'd0, x} * {16'd0, x}) >> 15;
        t = 32'd21024 - ((32'd2320 * x2) >> 15);
        t = 32'd51472 - ((t * x2) >> 15);
        s = ({32'd0, x} * {16'd0, t}) >> 16;
        sine_entry = quad[1] ? -$signed({1'b0, s[15:0]}) : $signed({1'b0, s[15:0]});
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        if (v > 36'sd32767) sat16 = 16'sh7FFF;
        else if (v < -36'sd32768) sat16 = 16'sh8000;
        else sat16 = v[15:0];
    endfunction
endpackage

// ===== hdl/foc_ctrl.sv =====
// Sequencer of the current loop: handshake and step order.
// Depends on foc_pkg and foc_current_loop_assert.svh.
`include "foc_current_loop_assert.svh"
module foc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output foc_pkg::t_dp_cmd  o_cmd
);
    import foc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_op, n_op;
    logic       r_phase, n_phase;
    logic       in_acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_phase = r_phase;
        o_cmd.valid = 1'b0;
        o_cmd.op    = OP_IDLE;
        o_cmd.phase = r_phase;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.valid = 1'b1;
                    o_cmd.op    = OP_LOAD;
                    n_state = S_RUN;
                    n_op    = OP_BETA;
                    n_phase = 1'b0;
                end
            end
            S_RUN: begin
                o_cmd.valid = 1'b1;
                o_cmd.op    = r_op;
                // Every step runs a multiply phase, then an accumulate phase.
                n_phase = ~r_phase;
                if (r_phase) begin
                    if (r_op == OP_IPARK_B) n_state = S_OUT;
                    else n_op = r_op + 4'd1;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_phase <= n_phase;
        end
    end

    `FOC_ASSERT_IMPL(a_ready_excl, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `FOC_ASSERT_IMPL(a_acc_run, i_clk, i_rst_n, in_acc |=> (r_state == S_RUN))
    `FOC_ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> o_out_valid)
endmodule

// ===== hdl/foc_dp.sv =====
// Datapath of the current loop: one shared multiply pair and accumulator,
// sine table, PI state and output register. Depends on foc_pkg.
module foc_dp #(
    parameter int SINE_TABLE_BITS = foc_pkg::SineTableBitsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  foc_pkg::t_dp_cmd i_cmd,
    input  foc_pkg::t_cfg    i_cfg,
    input  logic [79:0]      i_in_data,
    output logic [63:0]      o_out_data
);
    import foc_pkg::*;

    localparam int Shift = 16 - SINE_TABLE_BITS;
    localparam int TableSize = 2 ** SINE_TABLE_BITS;

    logic signed [15:0] r_ia, r_ib, r_td, r_tq;
    logic signed [16:0] r_sin, r_cos;
    logic signed [17:0] r_beta;
    logic signed [15:0] r_md, r_mq, r_va, r_vb;
    logic signed [15:0] r_drive_d, r_drive_q;
    logic signed [16:0] r_prev_d, r_prev_q;
    logic signed [16:0] r_err;
    logic signed [35:0] r_p0, r_p1;

    logic [SINE_TABLE_BITS-1:0] idx, cidx;
    logic signed [17:0] ma0, ma1;
    logic signed [17:0] mb0, mb1;
    logic signed [35:0] sum;
    logic signed [35:0] rnd14, rnd16;
    logic signed [19:0] nd;
    logic signed [16:0] lim;
    logic signed [16:0] err_sel;
    logic signed [16:0] sine_tab [TableSize];

    assign idx  = i_in_data[47:32+Shift];
    assign cidx = idx + SINE_TABLE_BITS'(1 << (SINE_TABLE_BITS - 2));

    // The polynomial is evaluated at elaboration only; the table is constant.
    for (genvar g = 0; g < TableSize; g++) begin : g_sine
        assign sine_tab[g] = sine_entry(16'(g << Shift));
    end

    always_comb begin
        err_sel = (i_cmd.op == OP_PI_D)
            ? 17'(r_td) - 17'(r_md) : 17'(r_tq) - 17'(r_mq);
        ma0 = '0; mb0 = '0; ma1 = '0; mb1 = '0;
        case (i_cmd.op)
            OP_BETA: begin
                ma0 = 18'(r_ia) + 18'(r_ib) + 18'(r_ib); mb0 = 18'sd37837;
            end
            OP_PARK_D: begin
                ma0 = 18'(r_ia); mb0 = 18'(r_cos); ma1 = r_beta; mb1 = 18'(r_sin);
            end
            OP_PARK_Q: begin
                ma0 = r_beta; mb0 = 18'(r_cos); ma1 = -18'(r_ia); mb1 = 18'(r_sin);
            end
            OP_PI_D: begin
                ma0 = 18'(i_cfg.kp_d); mb0 = 18'(err_sel) - 18'(r_prev_d);
                ma1 = 18'(i_cfg.ki_d); mb1 = 18'(err_sel);
            end
            OP_PI_Q: begin
                ma0 = 18'(i_cfg.kp_q); mb0 = 18'(err_sel) - 18'(r_prev_q);
                ma1 = 18'(i_cfg.ki_q); mb1 = 18'(err_sel);
            end
            OP_IPARK_A: begin
                ma0 = 18'(r_cos); mb0 = 18'(r_drive_d);
                ma1 = -18'(r_sin); mb1 = 18'(r_drive_q);
            end
            OP_IPARK_B: begin
                ma0 = 18'(r_sin); mb0 = 18'(r_drive_d);
                ma1 = 18'(r_cos); mb1 = 18'(r_drive_q);
            end
            default: ;
        endcase
        sum   = r_p0 + r_p1;
        rnd14 = (sum + 36'sd8192) >>> 14;
        rnd16 = (sum + 36'sd32768) >>> 16;
        lim   = (i_cmd.op == OP_PI_D) ? 17'(i_cfg.limit_d) : 17'(i_cfg.limit_q);
        nd    = 20'((i_cmd.op == OP_PI_D) ? r_drive_d : r_drive_q) + 20'(rnd16);
        if (nd > 20'(lim)) nd = 20'(lim);
        if (nd < -20'(lim)) nd = -20'(lim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_d <= '0; r_drive_q <= '0; r_prev_d <= '0; r_prev_q <= '0;
        end else if (i_cmd.valid && i_cmd.phase) begin
            if (i_cmd.op == OP_PI_D) begin
                r_drive_d <= nd[15:0]; r_prev_d <= r_err;
            end
            if (i_cmd.op == OP_PI_Q) begin
                r_drive_q <= nd[15:0]; r_prev_q <= r_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.valid) begin
            if (i_cmd.op == OP_LOAD) begin
                r_ia  <= i_in_data[15:0];
                r_ib  <= i_in_data[31:16];
                r_td  <= i_in_data[63:48];
                r_tq  <= i_in_data[79:64];
                r_sin <= sine_tab[idx];
                r_cos <= sine_tab[cidx];
            end else if (!i_cmd.phase) begin
                r_p0  <= ma0 * mb0;
                r_p1  <= ma1 * mb1;
                r_err <= err_sel;
            end else begin
                case (i_cmd.op)
                    OP_BETA:    r_beta <= rnd16[17:0];
                    OP_PARK_D:  r_md <= sat16(rnd14);
                    OP_PARK_Q:  r_mq <= sat16(rnd14);
                    OP_IPARK_A: r_va <= sat16(rnd14);
                    OP_IPARK_B: r_vb <= sat16(rnd14);
                    default: ;
                endcase
            end
        end
    end

    assign o_out_data = {r_mq, r_md, r_vb, r_va};
endmodule

// ===== hdl/foc_current_loop.sv =====
// Top level of the field-oriented current loop: config registers,
// controller and datapath. The result is computed in seven steps on the one
// shared multiplier pair, each a multiply and an accumulate phase; one item at
// a time, the next input is accepted the cycle after the result is taken.
// Synchronous active-low reset clears the PI state and loads the default gains.
`include "foc_current_loop_assert.svh"
module foc_current_loop #(
    parameter int SINE_TABLE_BITS = foc_pkg::SineTableBitsDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic [foc_pkg::CfgIdxWidth-1:0]  i_cfg_index,
    input  logic [foc_pkg::CfgDataWidth-1:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // phase_a_current, phase_b_current, elec_angle, target_d, target_q
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // volt_alpha, volt_beta, meas_d, meas_q
    output logic [63:0] m_axis_tdata
);
    import foc_pkg::*;

    t_cfg     r_cfg;
    t_dp_cmd  cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_d <= 16'd2621; r_cfg.ki_d <= 16'd5243;
            r_cfg.kp_q <= 16'd5243; r_cfg.ki_q <= 16'd5243;
            r_cfg.limit_d <= 15'd4096; r_cfg.limit_q <= 15'd12288;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_KP_D:    r_cfg.kp_d <= i_cfg_data;
                REG_KI_D:    r_cfg.ki_d <= i_cfg_data;
                REG_KP_Q:    r_cfg.kp_q <= i_cfg_data;
                REG_KI_Q:    r_cfg.ki_q <= i_cfg_data;
                REG_LIMIT_D: r_cfg.limit_d <= i_cfg_data[14:0];
                REG_LIMIT_Q: r_cfg.limit_q <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    foc_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_cmd(cmd)
    );

    foc_dp #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cfg(r_cfg),
        .i_in_data(s_axis_tdata), .o_out_data(m_axis_tdata)
    );

    `FOC_ASSERT_IMPL(a_out_stable, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    `FOC_ASSERT_IMPL(a_no_cmd_idle, i_clk, i_rst_n, m_axis_tvalid |-> !cmd.valid)
    `FOC_ASSERT_ALWAYS(a_no_overlap, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid))
endmodule
